// ===== rtl/core/pirc_pkg.sv =====
// Shared types and constants for the point-in-ring crossing test block.
// No dependencies; imported by the edge pipeline, the top level and the testbench.
package pirc_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int COORD_W          = 32;
    localparam int CNT_W            = 9;
    localparam int SLOT_W           = 8;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_TAIL,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } vertex_t;

    typedef struct packed {
        logic    valid;
        vertex_t a;
        vertex_t b;
    } edge_req_t;

    typedef struct packed {
        logic hit;
        logic busy;
    } edge_stat_t;

endpackage

// ===== rtl/core/pirc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pirc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pirc_edge.sv =====
// Three-stage edge test: translate, multiply, determinant sign and straddle.
// Depends on pirc_pkg for the edge request and status structs.
module pirc_edge
    import pirc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  edge_req_t                 req,
    input  logic signed [COORD_W-1:0] px,
    input  logic signed [COORD_W-1:0] py,
    output edge_stat_t                stat
);

    localparam int DW = COORD_W + 1;
    localparam int PW = 2 * DW;

    // stage 1: translated coordinates
    logic signed [DW-1:0] dx1_next, dy1_next, dx2_next, dy2_next;
    logic signed [DW-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic                 str1_next, dir1_next;
    logic                 str1_reg, dir1_reg, v1_reg;

    // stage 2: cross products
    logic signed [PW-1:0] p1_next, p2_next;
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic                 str2_reg, dir2_reg, v2_reg;

    // stage 3: verdict
    logic signed [PW:0]   det;
    logic                 hit_next;
    logic                 hit_reg, v3_reg;

    always_comb
    begin
        dx1_next  = {req.a.x[COORD_W-1], req.a.x} - {px[COORD_W-1], px};
        dy1_next  = {req.a.y[COORD_W-1], req.a.y} - {py[COORD_W-1], py};
        dx2_next  = {req.b.x[COORD_W-1], req.b.x} - {px[COORD_W-1], px};
        dy2_next  = {req.b.y[COORD_W-1], req.b.y} - {py[COORD_W-1], py};
        str1_next = (dy1_next > 0 && dy2_next <= 0) || (dy2_next > 0 && dy1_next <= 0);
        // when straddling, y2 - y1 is positive exactly when y2 is above the ray
        dir1_next = dy2_next > 0;
        p1_next   = dx1_reg * dy2_reg;
        p2_next   = dx2_reg * dy1_reg;
        det       = {p1_reg[PW-1], p1_reg} - {p2_reg[PW-1], p2_reg};
        hit_next  = v2_reg && str2_reg && (det != '0) && (det[PW] != dir2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            v1_reg  <= req.valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx1_reg  <= dx1_next;
        dy1_reg  <= dy1_next;
        dx2_reg  <= dx2_next;
        dy2_reg  <= dy2_next;
        str1_reg <= str1_next;
        dir1_reg <= dir1_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        str2_reg <= str1_reg;
        dir2_reg <= dir1_reg;
    end

    assign stat.hit  = hit_reg;
    assign stat.busy = v1_reg | v2_reg | v3_reg;

endmodule

// ===== rtl/core/point_in_ring_crossing_test_unit.sv =====
// Point-in-ring crossing test: load beats are taken back to back while idle; a query
// reads one vertex per cycle from the vertex RAM, then sends the closing edge and waits
// for the three-stage edge pipeline to drain. One query at a time.
// Reset clears control, the vertex count, the crossing counter and the valid flag
// of the result, not its total; the vertex RAM is not cleared and has no clearing pass.
// Depends on pirc_pkg, pirc_ram and pirc_edge.
module point_in_ring_crossing_test_unit
    import pirc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      op,
    input  logic [SLOT_W-1:0]         vertex_index,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      inside_res,
    output logic [CNT_W-1:0]          crossing_total,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CNT_W-1:0]          cfg_data
);

    localparam int AW = $clog2(MAX_VERTICES);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    vcount_reg;
    logic [CNT_W-1:0]    n_reg, n_next, n_clamp;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                rd_first_reg, rd_first_next;
    logic                rd_last_reg, rd_last_next;
    logic                close_reg, close_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]    out_total_reg, out_total_next;
    vertex_t             prev_reg, prev_next;
    vertex_t             first_reg, first_next;
    logic signed [COORD_W-1:0] px_reg, px_next, py_reg, py_next;

    logic                in_fire, query_start, out_load;
    logic                mem_we, mem_re;
    vertex_t             wr_vertex, rd_vertex;
    edge_req_t           req;
    edge_stat_t          stat;

    assign cfg_ready = 1'b1;
    assign in_stall  = state_reg != ST_IDLE;
    assign in_fire   = in_valid && !in_stall;

    assign mem_we    = in_fire && op == OP_LOAD && 32'(vertex_index) < 32'(MAX_VERTICES);
    assign wr_vertex = '{x: coord_x, y: coord_y};
    assign n_clamp   = (32'(vcount_reg) > 32'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                             : vcount_reg;

    pirc_ram #(
        .WIDTH ($bits(vertex_t)),
        .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(vertex_index)),
        .wdata (wr_vertex),
        .re    (mem_re),
        .raddr (AW'(rd_idx_reg)),
        .rdata (rd_vertex)
    );

    pirc_edge u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .px    (px_reg),
        .py    (py_reg),
        .stat  (stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        n_next         = n_reg;
        mem_re         = 1'b0;
        rd_pend_next   = 1'b0;
        rd_first_next  = 1'b0;
        rd_last_next   = 1'b0;
        query_start    = 1'b0;
        out_load       = 1'b0;
        px_next        = px_reg;
        py_next        = py_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && op == OP_QUERY)
                begin
                    query_start = 1'b1;
                    px_next     = coord_x;
                    py_next     = coord_y;
                    n_next      = n_clamp;
                    rd_idx_next = '0;
                    state_next  = (n_clamp == '0) ? ST_DONE : ST_READ;
                end
            end
            ST_READ:
            begin
                mem_re        = 1'b1;
                rd_pend_next  = 1'b1;
                rd_first_next = rd_idx_reg == '0;
                rd_last_next  = rd_idx_reg == n_reg - CNT_W'(1);
                rd_idx_next   = rd_idx_reg + CNT_W'(1);
                if (rd_last_next)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                if (close_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // vertex arrival: vertex 0 is kept for the closing edge, others pair with prev
    always_comb
    begin
        close_next = rd_pend_reg && rd_last_reg;
        prev_next  = rd_pend_reg ? rd_vertex : prev_reg;
        first_next = (rd_pend_reg && rd_first_reg) ? rd_vertex : first_reg;
        req        = '0;
        if (rd_pend_reg && !rd_first_reg)
        begin
            req.valid = 1'b1;
            req.a     = prev_reg;
            req.b     = rd_vertex;
        end
        else if (close_reg)
        begin
            req.valid = 1'b1;
            req.a     = prev_reg;
            req.b     = first_reg;
        end

        if (query_start)
        begin
            cnt_next = '0;
        end
        else if (stat.hit)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end

        out_valid_next = out_load || (out_valid_reg && out_stall);
        out_total_next = out_load ? cnt_reg : out_total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vcount_reg    <= '0;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            rd_first_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            close_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= cfg_data;
            end
            rd_idx_reg    <= rd_idx_next;
            rd_pend_reg   <= rd_pend_next;
            rd_first_reg  <= rd_first_next;
            rd_last_reg   <= rd_last_next;
            close_reg     <= close_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        prev_reg      <= prev_next;
        first_reg     <= first_next;
        out_total_reg <= out_total_next;
    end

    assign out_valid      = out_valid_reg;
    assign inside_res     = out_total_reg[0];
    assign crossing_total = out_total_reg;

    // nothing of a query may still be in flight once back in idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !rd_pend_reg && !close_reg && !stat.busy)
        else $error("query work in flight while idle");

    // every edge counts at most once
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |-> cnt_reg <= n_reg)
        else $error("crossing count exceeds edge count");

    // a result beat only comes out of the finishing state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside finishing state");

    // a crossing lands only while the walk or the drain is running
    a_hit_window: assert property (@(posedge clk) disable iff (!rst_n)
        stat.hit |-> state_reg == ST_READ || state_reg == ST_TAIL
                     || state_reg == ST_DRAIN)
        else $error("crossing counted outside a query");

endmodule

// ===== test/point_in_ring_crossing_test_unit_tb.sv =====
// Testbench for point_in_ring_crossing_test_unit: loads rings, sweeps the vertex count and checks
// every query verdict against an in-bench crossing-number predictor.
// Depends on pirc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module point_in_ring_crossing_test_unit_tb;
    import pirc_pkg::*;

    localparam int DEPTH       = MAX_VERTICES_DEF;
    localparam int IDLE_SETTLE = DEPTH + 16;
    localparam int ITEM_TARGET = 600;

    typedef enum int {
        SC_TINY,
        SC_MID,
        SC_FULL
    } coord_span_t;

    typedef struct packed {
        logic             in_ring;
        logic [CNT_W-1:0] total;
    } ring_verdict_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      op = OP_LOAD;
    logic [SLOT_W-1:0]         vertex_index = '0;
    logic signed [COORD_W-1:0] coord_x = '0;
    logic signed [COORD_W-1:0] coord_y = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      inside_res;
    logic [CNT_W-1:0]          crossing_total;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CNT_W-1:0]          cfg_data = '0;

    // bench copy of the block state
    logic signed [COORD_W-1:0] ring_x [DEPTH];
    logic signed [COORD_W-1:0] ring_y [DEPTH];
    logic [CNT_W-1:0]          ring_count = '0;
    ring_verdict_t             pending_verdicts [$];

    bit quiet_link = 1'b0;
    int items_sent = 0;
    int n_loads = 0;
    int n_queries = 0;
    int n_cfg = 0;
    int n_checked = 0;
    int mismatch_count = 0;
    int stall_left = 0;

    point_in_ring_crossing_test_unit #(
        .MAX_VERTICES(DEPTH)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .vertex_index   (vertex_index),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .inside_res     (inside_res),
        .crossing_total (crossing_total),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int used_edges();
        return (ring_count > DEPTH) ? DEPTH : int'(ring_count);
    endfunction

    // Even-odd crossing count of the rightward ray from (px, py); differences and the
    // determinant are carried wide enough to stay exact.
    function automatic ring_verdict_t count_ray_crossings(input logic signed [COORD_W-1:0] px,
                                                          input logic signed [COORD_W-1:0] py);
        int n;
        int j;
        int count;
        logic signed [COORD_W+1:0] x1;
        logic signed [COORD_W+1:0] y1;
        logic signed [COORD_W+1:0] x2;
        logic signed [COORD_W+1:0] y2;
        logic signed [2*COORD_W+3:0] det;
        ring_verdict_t v;
        n = used_edges();
        count = 0;
        for (int i = 0; i < n; i++)
        begin
            j = (i + 1 == n) ? 0 : i + 1;
            x1 = ring_x[i] - px;
            y1 = ring_y[i] - py;
            x2 = ring_x[j] - px;
            y2 = ring_y[j] - py;
            if ((y1 > 0 && y2 <= 0) || (y2 > 0 && y1 <= 0))
            begin
                det = x1 * y2 - x2 * y1;
                if (det != 0 && ((det > 0) == (y2 > y1)))
                    count++;
            end
        end
        v.in_ring = count[0];
        v.total   = count[CNT_W-1:0];
        return v;
    endfunction

    // mostly short idles, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord(input coord_span_t span);
        case (span)
            SC_TINY: return int'($urandom_range(0, 128)) - 64;
            SC_MID:  return int'($urandom_range(0, 1 << 21)) - (1 << 20);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin : out_stall_gen
        if (!rst_n || quiet_link)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 55)
            out_stall <= 1'b0;
        else
        begin
            stall_left = idle_len() - 1;
            out_stall <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : verdict_check
        ring_verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_checked++;
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result beat with nothing expected: inside=%0d total=%0d",
                             $time, inside_res, crossing_total);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (want.in_ring !== inside_res || want.total !== crossing_total)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch: expected %0d/%0d, got %0d/%0d (inside/total)",
                                 $time, want.in_ring, want.total, inside_res, crossing_total);
                end
            end
        end
    end

    // One input beat; valid stays up across back-to-back beats.
    task automatic send_beat(input logic o, input logic [SLOT_W-1:0] idx,
                             input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
        int gap;
        op           <= o;
        vertex_index <= idx;
        coord_x      <= x;
        coord_y      <= y;
        in_valid     <= 1'b1;
        do @(posedge clk); while (in_stall);
        if (o == OP_LOAD)
        begin
            ring_x[idx] = x;
            ring_y[idx] = y;
            n_loads++;
        end
        else
        begin
            pending_verdicts.push_back(count_ray_crossings(x, y));
            n_queries++;
        end
        items_sent++;
        gap = (quiet_link || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // always waits on the clock before returning so valid is not redriven in the same step
    task automatic hold_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_verdicts.size() != 0);
    endtask

    // loads leave nothing to wait on, so give a full query's worth of cycles
    task automatic settle_idle();
        hold_for_results();
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [CNT_W-1:0] value);
        settle_idle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        ring_count = value;
        n_cfg++;
    endtask

    task automatic send_query_near(input coord_span_t span, input int n_used);
        int r;
        int k;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
        r  = $urandom_range(0, 99);
        qx = rand_coord(span);
        qy = rand_coord(span);
        if (n_used > 0 && r < 20)
            qy = ring_y[$urandom_range(0, n_used - 1)];
        else if (n_used > 0 && r < 30)
        begin
            k  = $urandom_range(0, n_used - 1);
            qx = ring_x[k];
            qy = ring_y[k];
        end
        else if (r < 45)
        begin
            qx = $urandom;
            qy = $urandom;
        end
        send_beat(OP_QUERY, SLOT_W'($urandom), qx, qy);
    endtask

    task automatic test_extreme_square();
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
        lo = {1'b1, {(COORD_W-1){1'b0}}};
        hi = {1'b0, {(COORD_W-1){1'b1}}};
        send_beat(OP_LOAD, 0, lo, lo);
        send_beat(OP_LOAD, 1, hi, lo);
        send_beat(OP_LOAD, 2, hi, hi);
        send_beat(OP_LOAD, 3, lo, hi);
        write_vertex_count(4);
        send_beat(OP_QUERY, 0, 0, 0);
        send_beat(OP_QUERY, '1, lo, lo);
        send_beat(OP_QUERY, 0, hi, hi);
        send_beat(OP_QUERY, 0, lo, 0);
        send_beat(OP_QUERY, 0, hi, -1);
    endtask

    // counts of zero, one and two vertices
    task automatic test_short_counts();
        write_vertex_count(0);
        send_beat(OP_QUERY, 0, 0, 0);
        write_vertex_count(1);
        send_beat(OP_QUERY, 0, -5, -5);
        write_vertex_count(2);
        send_beat(OP_QUERY, 0, 0, 0);
        send_beat(OP_QUERY, 0, -100, 0);
    endtask

    task automatic test_repeated_and_ray_vertex();
        send_beat(OP_LOAD, 0, 0, 0);
        send_beat(OP_LOAD, 1, 100, 0);
        send_beat(OP_LOAD, 2, 100, 100);
        send_beat(OP_LOAD, 3, 100, 100);
        send_beat(OP_LOAD, 4, 0, 100);
        write_vertex_count(5);
        send_beat(OP_QUERY, 0, 50, 50);
        send_beat(OP_QUERY, 0, 50, 100);
        send_beat(OP_QUERY, 0, 50, 0);
        send_beat(OP_QUERY, 0, -10, 100);
        send_beat(OP_QUERY, 0, 150, 50);
    endtask

    // Zigzag across y = 0 over every slot: every edge, the closing one too, crosses a ray from the left.
    task automatic test_full_ring();
        quiet_link <= 1'b1;
        write_vertex_count('1);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i % 2 == 0)
                send_beat(OP_LOAD, SLOT_W'(i), 1000 + int'($urandom_range(0, 1 << 30)),
                          int'($urandom_range(1, 1 << 20)));
            else
                send_beat(OP_LOAD, SLOT_W'(i), 1000 + int'($urandom_range(0, 1 << 30)),
                          -int'($urandom_range(0, 1 << 20)));
        end
        quiet_link <= 1'b0;
        repeat (6) send_beat(OP_QUERY, 0, -int'($urandom_range(0, 1000)), 0);
        repeat (4) send_query_near(SC_MID, DEPTH);
        write_vertex_count(9'h100);
        send_beat(OP_QUERY, 0, 0, 0);
        repeat (2) send_query_near(SC_FULL, DEPTH);
    endtask

    task automatic test_random_rings();
        int cnt;
        int n_used;
        int k;
        int r;
        coord_span_t span;
        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                cnt = $urandom_range(0, 2);
            else if (r < 75)
                cnt = $urandom_range(3, 10);
            else if (r < 92)
                cnt = $urandom_range(11, 40);
            else if (r < 96)
                cnt = DEPTH;
            else
                cnt = $urandom_range(DEPTH + 1, (1 << CNT_W) - 1);
            quiet_link <= ($urandom_range(0, 4) == 0);
            write_vertex_count(CNT_W'(cnt));
            n_used = used_edges();
            span = coord_span_t'($urandom_range(0, 2));
            // big rings reuse the table filled earlier and only touch a few slots
            if (n_used <= 40)
            begin
                for (int i = 0; i < n_used; i++)
                    send_beat(OP_LOAD, SLOT_W'(i), rand_coord(span), rand_coord(span));
                k = $urandom_range(4, 14);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_beat(OP_LOAD, SLOT_W'($urandom_range(0, n_used - 1)),
                              rand_coord(span), rand_coord(span));
                k = $urandom_range(2, 5);
            end
            repeat (k)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    hold_for_results();
                if (r < 70 || n_used == 0)
                    send_query_near(span, n_used);
                else if (r < 85 && n_used < DEPTH)
                    send_beat(OP_LOAD, SLOT_W'($urandom_range(n_used, DEPTH - 1)),
                              $urandom, $urandom);
                else
                    send_beat(OP_LOAD, SLOT_W'($urandom_range(0, n_used - 1)),
                              rand_coord(span), rand_coord(span));
            end
        end
        quiet_link <= 1'b0;
    endtask

    initial
    begin : regression
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extreme_square();
        test_short_counts();
        test_repeated_and_ray_vertex();
        test_full_ring();
        test_random_rings();
        settle_idle();
        $display("covered %0d vertex loads, %0d queries, %0d count writes (0 up to 511)",
                 n_loads, n_queries, n_cfg);
        $display("checked %0d verdict beats, %0d mismatches", n_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("point_in_ring_crossing_test_unit regression: pass");
        else
            $display("point_in_ring_crossing_test_unit regression: fail");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("timeout with %0d verdicts outstanding", pending_verdicts.size());
        $display("point_in_ring_crossing_test_unit regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pirc_pkg.sv
rtl/core/pirc_ram.sv
rtl/core/pirc_edge.sv
rtl/core/point_in_ring_crossing_test_unit.sv
test/point_in_ring_crossing_test_unit_tb.sv
